@@ hdl/hbfm_pkg.sv @@
package hbfm_pkg;

	localparam int KEY_W   = 32;
	localparam int EPOCH_W = 64;
	localparam int TIME_W  = 48;
	localparam int TMO_W   = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W   = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_HA_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd1;
	localparam logic [TMO_W-1:0]     TIMEOUT_RESET = 32'd3000;

	localparam logic [2:0] CMD_HEARTBEAT = 3'd0;
	localparam logic [2:0] CMD_PEER_TMO  = 3'd1;
	localparam logic [2:0] CMD_ELECTION  = 3'd2;
	localparam logic [2:0] CMD_TICK      = 3'd3;
	localparam logic [2:0] CMD_QUERY     = 3'd4;
	localparam logic [2:0] CMD_SET_ROLE  = 3'd5;
	localparam logic [2:0] CMD_START     = 3'd6;
	localparam logic [2:0] CMD_STOP      = 3'd7;

	localparam logic [1:0] ROLE_STANDALONE = 2'd0;
	localparam logic [1:0] ROLE_PRIMARY    = 2'd1;
	localparam logic [1:0] ROLE_SECONDARY  = 2'd2;
	localparam logic [1:0] ROLE_INVALID    = 2'd3;

	localparam logic [2:0] RUN_CREATED  = 3'd0;
	localparam logic [2:0] RUN_RUNNING  = 3'd1;
	localparam logic [2:0] RUN_DEGRADED = 3'd2;
	localparam logic [2:0] RUN_STOPPED  = 3'd3;
	localparam logic [2:0] RUN_FAULTED  = 3'd4;

	localparam logic [2:0] RC_OK            = 3'd0;
	localparam logic [2:0] RC_INVALID_STATE = 3'd1;
	localparam logic [2:0] RC_DENIED        = 3'd2;
	localparam logic [2:0] RC_FULL          = 3'd3;
	localparam logic [2:0] RC_NOT_FOUND     = 3'd4;
	localparam logic [2:0] RC_INVALID_PARAM = 3'd5;
	localparam logic [2:0] RC_START_FAILED  = 3'd6;

	localparam logic [EPOCH_W-1:0] EPOCH_RESET = 64'd1;

	typedef struct packed {
		logic [2:0]         command;
		logic [KEY_W-1:0]   peer_key;
		logic [EPOCH_W-1:0] remote_epoch;
		logic [TIME_W-1:0]  now_ms;
		logic [1:0]         role_value;
		logic               admitted;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [1:0]         role_out;
		logic [2:0]         run_state;
		logic [EPOCH_W-1:0] epoch_out;
		logic [EPOCH_W-1:0] found_epoch;
		logic [TIME_W-1:0]  found_last_seen;
		logic               found_healthy;
	} rsp_t;

	// request context broadcast to all cells while the token travels
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] now;
		logic [TMO_W-1:0]  timeout;
		logic              tick_en;
	} scan_t;

	// slot update broadcast at commit
	typedef struct packed {
		logic               en;
		logic [KEY_W-1:0]   key;
		logic [EPOCH_W-1:0] epoch;
		logic [TIME_W-1:0]  now;
	} wr_t;

	// token handed from cell to cell
	typedef struct packed {
		logic               act;
		logic               hit;
		logic               free_seen;
		logic               any_healthy;
		logic [EPOCH_W-1:0] f_epoch;
		logic [TIME_W-1:0]  f_seen;
		logic               f_healthy;
	} tok_t;

	typedef enum logic [2:0] {
		FSM_IDLE = 3'b001,
		FSM_SCAN = 3'b010,
		FSM_DONE = 3'b100
	} fsm_t;

endpackage

@@ hdl/heartbeat_failover_monitor.sv @@
// channel | valid     | stall     | payload
// request | req_valid | req_stall | req (req_t)
// result  | rsp_valid | rsp_stall | rsp (rsp_t)
// config  | cfg_we    | -         | cfg_index, cfg_data
//
// A request is answered after a token walks the row of slot cells one cell
// per cycle, the tail register captures it and the commit step writes the
// result. The next request can be taken in the cycle after commit.
// One request is in work at a time; a new one is taken while the last
// result still waits. Commit holds while the result register is full and stalled.
// Reset clears slot use and health, and sets role, epoch, run state and both config registers to their reset values.
module heartbeat_failover_monitor
	import hbfm_pkg::*;
#(
	parameter int PEER_SLOTS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int IW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;

	fsm_t               state_q;
	req_t               req_q;
	logic               start_q;
	logic               ha_en_q;
	logic [TMO_W-1:0]   timeout_q;
	logic [1:0]         role_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [2:0]         run_q;
	logic               started_q;
	tok_t               tail_q;
	logic [IW-1:0]      tail_hit_q;
	logic [IW-1:0]      tail_free_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	tok_t          tok      [PEER_SLOTS+1];
	logic [IW-1:0] hit_idx  [PEER_SLOTS+1];
	logic [IW-1:0] free_idx [PEER_SLOTS+1];

	scan_t         scan;
	wr_t           wr;
	logic [IW-1:0] wr_idx;
	logic          accept;
	logic          commit;

	logic [2:0]         status_n;
	logic [1:0]         role_n;
	logic [EPOCH_W-1:0] epoch_n;
	logic [2:0]         run_n;
	logic               started_n;
	logic               found_n;

	assign req_stall = (state_q != FSM_IDLE);
	assign accept    = req_valid && !req_stall;
	assign commit    = (state_q == FSM_DONE) && (!rsp_valid_q || !rsp_stall);

	assign scan.key     = req_q.peer_key;
	assign scan.now     = req_q.now_ms;
	assign scan.timeout = timeout_q;
	assign scan.tick_en = (req_q.command == CMD_TICK) && started_q && ha_en_q;

	always_comb begin
		tok[0]             = '0;
		tok[0].act         = start_q;
		hit_idx[0]         = '0;
		free_idx[0]        = '0;
	end

	for (genvar i = 0; i < PEER_SLOTS; i++) begin : g_cell
		hbfm_cell #(
			.IW  (IW),
			.IDX (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.scan         (scan),
			.wr           (wr),
			.wr_idx       (wr_idx),
			.tok_in       (tok[i]),
			.hit_idx_in   (hit_idx[i]),
			.free_idx_in  (free_idx[i]),
			.tok_out      (tok[i+1]),
			.hit_idx_out  (hit_idx[i+1]),
			.free_idx_out (free_idx[i+1])
		);
	end

	always_comb begin
		status_n  = RC_OK;
		role_n    = role_q;
		epoch_n   = epoch_q;
		run_n     = run_q;
		started_n = started_q;
		found_n   = 1'b0;
		wr.en     = 1'b0;
		wr.key    = req_q.peer_key;
		wr.epoch  = req_q.remote_epoch;
		wr.now    = req_q.now_ms;
		wr_idx    = tail_q.hit ? tail_hit_q : tail_free_q;
		unique case (req_q.command)
			CMD_HEARTBEAT: begin
				if (!ha_en_q) begin
					status_n = RC_INVALID_STATE;
				end else if (!req_q.admitted) begin
					status_n = RC_DENIED;
				end else if (!tail_q.hit && !tail_q.free_seen) begin
					status_n = RC_FULL;
				end else begin
					wr.en = commit;
					if (req_q.remote_epoch >= epoch_q) begin
						epoch_n = req_q.remote_epoch;
						role_n  = ROLE_SECONDARY;
						if (started_q && run_q == RUN_DEGRADED) begin
							run_n = RUN_RUNNING;
						end
					end
				end
			end
			CMD_PEER_TMO: begin
				if (!ha_en_q) begin
					status_n = RC_INVALID_STATE;
				end else if (role_q != ROLE_PRIMARY) begin
					role_n  = ROLE_PRIMARY;
					epoch_n = epoch_q + 1'b1;
					run_n   = RUN_DEGRADED;
				end
			end
			CMD_ELECTION: begin
				if (!ha_en_q) begin
					status_n = RC_INVALID_STATE;
				end else begin
					if (role_q != ROLE_PRIMARY) begin
						role_n  = ROLE_PRIMARY;
						epoch_n = epoch_q + 1'b1;
					end
					run_n = RUN_RUNNING;
				end
			end
			CMD_TICK: begin
				if (!started_q || !ha_en_q) begin
					status_n = RC_INVALID_STATE;
				end else if (!tail_q.any_healthy && role_q != ROLE_PRIMARY) begin
					role_n  = ROLE_PRIMARY;
					epoch_n = epoch_q + 1'b1;
					run_n   = RUN_DEGRADED;
				end else if (tail_q.any_healthy && run_q == RUN_DEGRADED) begin
					run_n = RUN_RUNNING;
				end
			end
			CMD_QUERY: begin
				if (tail_q.hit) begin
					found_n = 1'b1;
				end else begin
					status_n = RC_NOT_FOUND;
				end
			end
			CMD_SET_ROLE: begin
				if (req_q.role_value == ROLE_INVALID) begin
					status_n = RC_INVALID_PARAM;
				end else begin
					role_n = req_q.role_value;
				end
			end
			CMD_START: begin
				if (!started_q) begin
					if (!req_q.admitted) begin
						run_n    = RUN_FAULTED;
						status_n = RC_START_FAILED;
					end else begin
						started_n = 1'b1;
						run_n     = RUN_RUNNING;
					end
				end
			end
			CMD_STOP: begin
				started_n = 1'b0;
				run_n     = RUN_STOPPED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			start_q     <= 1'b0;
			ha_en_q     <= 1'b0;
			timeout_q   <= TIMEOUT_RESET;
			role_q      <= ROLE_STANDALONE;
			epoch_q     <= EPOCH_RESET;
			run_q       <= RUN_CREATED;
			started_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			start_q <= accept;
			unique case (state_q)
				FSM_IDLE: begin
					if (accept) begin
						state_q <= FSM_SCAN;
					end
				end
				FSM_SCAN: begin
					if (tok[PEER_SLOTS].act) begin
						state_q <= FSM_DONE;
					end
				end
				FSM_DONE: begin
					if (commit) begin
						state_q <= FSM_IDLE;
					end
				end
				default: begin
					state_q <= FSM_IDLE;
				end
			endcase

			if (commit) begin
				role_q    <= role_n;
				epoch_q   <= epoch_n;
				run_q     <= run_n;
				started_q <= started_n;
			end else if (cfg_we) begin
				if (cfg_index == CFG_HA_ENABLE) begin
					ha_en_q <= cfg_data[0];
					if (cfg_data[0]) begin
						role_q <= ROLE_SECONDARY;
					end
				end else if (cfg_index == CFG_TIMEOUT) begin
					timeout_q <= cfg_data[TMO_W-1:0];
				end
			end

			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (state_q == FSM_SCAN && tok[PEER_SLOTS].act) begin
			tail_q      <= tok[PEER_SLOTS];
			tail_hit_q  <= hit_idx[PEER_SLOTS];
			tail_free_q <= free_idx[PEER_SLOTS];
		end
		if (commit) begin
			rsp_q.status          <= status_n;
			rsp_q.role_out        <= role_n;
			rsp_q.run_state       <= run_n;
			rsp_q.epoch_out       <= epoch_n;
			rsp_q.found_epoch     <= found_n ? tail_q.f_epoch : '0;
			rsp_q.found_last_seen <= found_n ? tail_q.f_seen : '0;
			rsp_q.found_healthy   <= found_n && tail_q.f_healthy;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ hdl/hbfm_cell.sv @@
module hbfm_cell
	import hbfm_pkg::*;
#(
	parameter int IW  = 3,
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  scan_t         scan,
	input  wr_t           wr,
	input  logic [IW-1:0] wr_idx,
	input  tok_t          tok_in,
	input  logic [IW-1:0] hit_idx_in,
	input  logic [IW-1:0] free_idx_in,
	output tok_t          tok_out,
	output logic [IW-1:0] hit_idx_out,
	output logic [IW-1:0] free_idx_out
);

	logic               used_q;
	logic               healthy_q;
	logic [KEY_W-1:0]   key_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [TIME_W-1:0]  seen_q;

	tok_t          tok_q;
	logic [IW-1:0] hit_idx_q;
	logic [IW-1:0] free_idx_q;

	tok_t          tok_n;
	logic [IW-1:0] hit_idx_n;
	logic [IW-1:0] free_idx_n;
	logic          mine;
	logic          own_hit;
	logic          later;
	logic [TIME_W-1:0] age;
	logic          lost;
	logic          heal_clr;

	assign mine    = wr.en && (wr_idx == IW'(IDX));
	assign own_hit = used_q && (key_q == scan.key);
	assign later   = scan.now > seen_q;
	assign age     = scan.now - seen_q;
	assign lost    = later && (age > TIME_W'(scan.timeout));

	always_comb begin
		tok_n      = tok_in;
		hit_idx_n  = hit_idx_in;
		free_idx_n = free_idx_in;
		heal_clr   = 1'b0;
		if (tok_in.act) begin
			if (!tok_in.hit && own_hit) begin
				tok_n.hit       = 1'b1;
				tok_n.f_epoch   = epoch_q;
				tok_n.f_seen    = seen_q;
				tok_n.f_healthy = healthy_q;
				hit_idx_n       = IW'(IDX);
			end
			if (!tok_in.free_seen && !used_q) begin
				tok_n.free_seen = 1'b1;
				free_idx_n      = IW'(IDX);
			end
			if (scan.tick_en && used_q && healthy_q) begin
				if (lost) begin
					heal_clr = 1'b1;
				end else begin
					tok_n.any_healthy = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= 1'b0;
			healthy_q <= 1'b0;
			tok_q     <= '0;
		end else begin
			tok_q <= tok_n;
			if (mine) begin
				used_q    <= 1'b1;
				healthy_q <= 1'b1;
			end else if (heal_clr) begin
				healthy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		hit_idx_q  <= hit_idx_n;
		free_idx_q <= free_idx_n;
		if (mine) begin
			key_q   <= wr.key;
			epoch_q <= wr.epoch;
			seen_q  <= wr.now;
		end
	end

	assign tok_out      = tok_q;
	assign hit_idx_out  = hit_idx_q;
	assign free_idx_out = free_idx_q;

endmodule

@@ tb/hbfm_check_pkg.sv @@
`timescale 1ns / 1ps
package hbfm_check_pkg;
	import hbfm_pkg::*;

	localparam int TABLE_DEPTH = 8;
	localparam int PRINT_LIMIT = 40;

	class hbfm_scoreboard;
		bit               used[TABLE_DEPTH];
		bit [KEY_W-1:0]   keys[TABLE_DEPTH];
		bit [EPOCH_W-1:0] slot_epochs[TABLE_DEPTH];
		bit [TIME_W-1:0]  seen[TABLE_DEPTH];
		bit               healthy[TABLE_DEPTH];
		bit [1:0]         role;
		bit [EPOCH_W-1:0] epoch;
		bit [2:0]         run;
		bit               started;
		bit               ha_on;
		bit [TMO_W-1:0]   timeout;
		rsp_t             owed[$];
		int               errors;

		function new();
			role    = ROLE_STANDALONE;
			epoch   = EPOCH_RESET;
			run     = RUN_CREATED;
			started = 1'b0;
			ha_on   = 1'b0;
			timeout = TIMEOUT_RESET;
			errors  = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			if (idx == CFG_HA_ENABLE) begin
				ha_on = data[0];
				if (ha_on)
					role = ROLE_SECONDARY;
			end else if (idx == CFG_TIMEOUT) begin
				timeout = data;
			end
		endfunction

		function int find_slot(logic [KEY_W-1:0] key);
			for (int i = 0; i < TABLE_DEPTH; i++)
				if (used[i] && keys[i] == key)
					return i;
			return -1;
		endfunction

		function int occupancy();
			int n;
			n = 0;
			for (int i = 0; i < TABLE_DEPTH; i++)
				n += used[i];
			return n;
		endfunction

		function void promote();
			role  = ROLE_PRIMARY;
			epoch = epoch + 1'b1;
		endfunction

		// apply one accepted request and queue the response it owes
		function void note_request(req_t r);
			rsp_t             o;
			int               s;
			bit               any;
			bit [TIME_W-1:0]  age;
			o = '0;
			o.status = RC_OK;
			case (r.command)
				CMD_HEARTBEAT: begin
					if (!ha_on) begin
						o.status = RC_INVALID_STATE;
					end else if (!r.admitted) begin
						o.status = RC_DENIED;
					end else begin
						s = find_slot(r.peer_key);
						if (s < 0)
							for (int i = 0; i < TABLE_DEPTH; i++)
								if (!used[i] && s < 0)
									s = i;
						if (s < 0) begin
							o.status = RC_FULL;
						end else begin
							used[s]        = 1'b1;
							keys[s]        = r.peer_key;
							slot_epochs[s] = r.remote_epoch;
							seen[s]        = r.now_ms;
							healthy[s]     = 1'b1;
							if (r.remote_epoch >= epoch) begin
								epoch = r.remote_epoch;
								role  = ROLE_SECONDARY;
								if (started && run == RUN_DEGRADED)
									run = RUN_RUNNING;
							end
						end
					end
				end
				CMD_PEER_TMO: begin
					if (!ha_on) begin
						o.status = RC_INVALID_STATE;
					end else if (role != ROLE_PRIMARY) begin
						promote();
						run = RUN_DEGRADED;
					end
				end
				CMD_ELECTION: begin
					if (!ha_on) begin
						o.status = RC_INVALID_STATE;
					end else begin
						if (role != ROLE_PRIMARY)
							promote();
						run = RUN_RUNNING;
					end
				end
				CMD_TICK: begin
					if (!started || !ha_on) begin
						o.status = RC_INVALID_STATE;
					end else begin
						any = 1'b0;
						for (int i = 0; i < TABLE_DEPTH; i++) begin
							if (used[i] && healthy[i]) begin
								age = (r.now_ms > seen[i]) ? r.now_ms - seen[i] : '0;
								if (age > timeout)
									healthy[i] = 1'b0;
								else
									any = 1'b1;
							end
						end
						if (!any && role != ROLE_PRIMARY) begin
							promote();
							run = RUN_DEGRADED;
						end else if (any && run == RUN_DEGRADED) begin
							run = RUN_RUNNING;
						end
					end
				end
				CMD_QUERY: begin
					s = find_slot(r.peer_key);
					if (s < 0) begin
						o.status = RC_NOT_FOUND;
					end else begin
						o.found_epoch     = slot_epochs[s];
						o.found_last_seen = seen[s];
						o.found_healthy   = healthy[s];
					end
				end
				CMD_SET_ROLE: begin
					if (r.role_value == ROLE_INVALID)
						o.status = RC_INVALID_PARAM;
					else
						role = r.role_value;
				end
				CMD_START: begin
					if (!started) begin
						if (!r.admitted) begin
							run = RUN_FAULTED;
							o.status = RC_START_FAILED;
						end else begin
							started = 1'b1;
							run = RUN_RUNNING;
						end
					end
				end
				CMD_STOP: begin
					started = 1'b0;
					run = RUN_STOPPED;
				end
			endcase
			o.role_out  = role;
			o.run_state = run;
			o.epoch_out = epoch;
			owed.push_back(o);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= PRINT_LIMIT)
				$display("%0t mismatch: %s", $realtime, msg);
		endtask

		task check_result(rsp_t got);
			rsp_t want;
			if (owed.size() == 0) begin
				report($sformatf("unexpected response %h", got));
				return;
			end
			want = owed.pop_front();
			if (got.status !== want.status)
				report($sformatf("status got %0d want %0d", got.status, want.status));
			if (got.role_out !== want.role_out)
				report($sformatf("role_out got %0d want %0d", got.role_out, want.role_out));
			if (got.run_state !== want.run_state)
				report($sformatf("run_state got %0d want %0d", got.run_state, want.run_state));
			if (got.epoch_out !== want.epoch_out)
				report($sformatf("epoch_out got %h want %h", got.epoch_out, want.epoch_out));
			if (got.found_epoch !== want.found_epoch)
				report($sformatf("found_epoch got %h want %h", got.found_epoch,
					want.found_epoch));
			if (got.found_last_seen !== want.found_last_seen)
				report($sformatf("found_last_seen got %h want %h", got.found_last_seen,
					want.found_last_seen));
			if (got.found_healthy !== want.found_healthy)
				report($sformatf("found_healthy got %b want %b", got.found_healthy,
					want.found_healthy));
		endtask
	endclass

endpackage

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
	import hbfm_pkg::*;
	import hbfm_check_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_CYCLES = 2 * (TABLE_DEPTH + 3);

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	hbfm_scoreboard    sb;
	logic [KEY_W-1:0]  key_pool[TABLE_DEPTH];
	logic [TIME_W-1:0] now_base;
	int                stall_mode = 0;
	int                stall_left = 0;

	heartbeat_failover_monitor i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall)
				sb.check_result(rsp);
			if (req_valid && !req_stall)
				sb.note_request(req);
		end
	end

	// response back-pressure: modes of random length
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(64, 400);
		end else begin
			stall_left = stall_left - 1;
		end
		case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= ($urandom_range(0, 99) < 30);
			2: rsp_stall <= ($urandom_range(0, 99) < 75);
			default: rsp_stall <= ((stall_left % 7) < 3);
		endcase
	end

	function automatic req_t make_req(logic [2:0] cmd, logic [KEY_W-1:0] key,
		logic [EPOCH_W-1:0] ep, logic [TIME_W-1:0] now, logic [1:0] rv, logic adm);
		req_t r;
		r.command      = cmd;
		r.peer_key     = key;
		r.remote_epoch = ep;
		r.now_ms       = now;
		r.role_value   = rv;
		r.admitted     = adm;
		return r;
	endfunction

	task automatic send(input req_t item);
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic pause_sender(input int cycles);
		req_valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (sb.owed.size() != 0)
			@(negedge clk);
	endtask

	task automatic configure(input logic ha, input logic [TMO_W-1:0] tmo);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= CFG_HA_ENABLE;
		cfg_data <= CFG_W'(ha);
		sb.write_reg(CFG_HA_ENABLE, CFG_W'(ha));
		@(negedge clk);
		cfg_index <= CFG_TIMEOUT;
		cfg_data <= tmo;
		sb.write_reg(CFG_TIMEOUT, tmo);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(input int count);
		req_t r;
		int   sent;
		int   burst;
		int   w;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 16);
			while (burst > 0 && sent < count) begin
				r.peer_key     = $urandom;
				r.remote_epoch = {$urandom, $urandom};
				r.now_ms       = TIME_W'({$urandom, $urandom});
				r.role_value   = 2'($urandom_range(0, 3));
				r.admitted     = ($urandom_range(0, 9) != 0);
				w = $urandom_range(0, 99);
				if (w < 34)
					r.command = CMD_HEARTBEAT;
				else if (w < 56)
					r.command = CMD_TICK;
				else if (w < 70)
					r.command = CMD_QUERY;
				else if (w < 76)
					r.command = CMD_PEER_TMO;
				else if (w < 82)
					r.command = CMD_ELECTION;
				else if (w < 91)
					r.command = CMD_SET_ROLE;
				else if (w < 97)
					r.command = CMD_START;
				else
					r.command = CMD_STOP;

				if (r.command == CMD_HEARTBEAT) begin
					// foreign keys only once the pool owns the whole table
					if (!(sb.occupancy() == TABLE_DEPTH && $urandom_range(0, 9) == 0))
						r.peer_key = key_pool[$urandom_range(0, TABLE_DEPTH - 1)];
					w = $urandom_range(0, 99);
					if (w >= 4 && w < 55)
						r.remote_epoch = sb.epoch + $urandom_range(0, 2);
					else if (w >= 55)
						r.remote_epoch = sb.epoch - $urandom_range(1, 3);
				end else if (r.command == CMD_QUERY && $urandom_range(0, 99) < 85) begin
					r.peer_key = key_pool[$urandom_range(0, TABLE_DEPTH - 1)];
				end

				if (r.command == CMD_HEARTBEAT || r.command == CMD_TICK) begin
					w = $urandom_range(0, 99);
					if (w >= 5 && w < 15) begin
						r.now_ms = now_base - $urandom_range(0, 2500);
					end else if (w >= 15) begin
						now_base = now_base + $urandom_range(0, 1200);
						r.now_ms = now_base;
					end
				end

				send(r);
				burst--;
				sent++;
			end
			w = $urandom_range(0, 99);
			if (w < 3)
				drain();
			else if (w >= 40)
				pause_sender($urandom_range(1, 12));
		end
	endtask

	initial begin
		sb = new();
		now_base = 48'd10000;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < TABLE_DEPTH; i++)
			key_pool[i] = $urandom;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// failover disabled, node not started
		send(make_req(CMD_HEARTBEAT, key_pool[0], 64'd7, 48'd10, ROLE_STANDALONE, 1'b1));
		send(make_req(CMD_PEER_TMO, '0, '0, '0, ROLE_STANDALONE, 1'b0));
		send(make_req(CMD_ELECTION, '0, '0, '0, ROLE_STANDALONE, 1'b0));
		send(make_req(CMD_TICK, '0, '0, '1, ROLE_STANDALONE, 1'b1));
		send(make_req(CMD_QUERY, key_pool[0], '0, '0, ROLE_STANDALONE, 1'b0));
		send(make_req(CMD_SET_ROLE, '0, '0, '0, ROLE_INVALID, 1'b0));
		send(make_req(CMD_SET_ROLE, '0, '0, '0, ROLE_PRIMARY, 1'b0));
		send(make_req(CMD_START, '0, '0, '0, ROLE_STANDALONE, 1'b0));
		send(make_req(CMD_START, '0, '0, '0, ROLE_STANDALONE, 1'b1));
		send(make_req(CMD_START, '0, '0, '0, ROLE_STANDALONE, 1'b0));
		send(make_req(CMD_TICK, '0, '0, 48'd50, ROLE_STANDALONE, 1'b1));

		configure(1'b1, 32'd1000);
		send(make_req(CMD_HEARTBEAT, key_pool[0], 64'd3, 48'd50, ROLE_STANDALONE, 1'b0));
		send(make_req(CMD_HEARTBEAT, key_pool[0], 64'd0, 48'd100, ROLE_STANDALONE, 1'b1));
		send(make_req(CMD_HEARTBEAT, key_pool[1], 64'd5, 48'd200, ROLE_STANDALONE, 1'b1));
		send(make_req(CMD_HEARTBEAT, key_pool[0], 64'd5, 48'd300, ROLE_STANDALONE, 1'b1));
		send(make_req(CMD_QUERY, key_pool[0], '0, '0, ROLE_STANDALONE, 1'b0));
		send(make_req(CMD_TICK, '0, '0, 48'd1300, ROLE_STANDALONE, 1'b1));
		send(make_req(CMD_TICK, '0, '0, 48'd5000, ROLE_STANDALONE, 1'b1));
		send(make_req(CMD_HEARTBEAT, key_pool[2], '1, 48'd5000, ROLE_STANDALONE, 1'b1));
		send(make_req(CMD_PEER_TMO, '0, '0, '0, ROLE_STANDALONE, 1'b0));
		send(make_req(CMD_PEER_TMO, '0, '0, '0, ROLE_STANDALONE, 1'b0));
		send(make_req(CMD_ELECTION, '0, '0, '0, ROLE_STANDALONE, 1'b0));
		send(make_req(CMD_SET_ROLE, '0, '0, '0, ROLE_STANDALONE, 1'b0));
		send(make_req(CMD_ELECTION, '0, '0, '0, ROLE_STANDALONE, 1'b0));
		send(make_req(CMD_TICK, '0, '0, '0, ROLE_STANDALONE, 1'b1));
		send(make_req(CMD_STOP, '0, '0, '0, ROLE_STANDALONE, 1'b0));
		send(make_req(CMD_TICK, '0, '0, 48'd6000, ROLE_STANDALONE, 1'b1));
		send(make_req(CMD_START, '0, '0, '0, ROLE_STANDALONE, 1'b1));

		configure(1'b1, TIMEOUT_RESET);
		random_phase(90);
		configure(1'b1, '0);
		random_phase(60);
		configure(1'b1, '1);
		random_phase(70);
		configure(1'b0, 32'd2000);
		random_phase(40);
		configure(1'b1, $urandom_range(200, 5000));
		random_phase(90);
		configure(1'b1, 32'd1500);
		random_phase(100);

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || cfg_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle = 0;
			else
				idle++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
